FILE: hw/rtl/max_heap_priority_queue_core_assert.svh
// Assertion macros for the max-heap priority queue core.
// Depends on i_clk and i_rst_n being visible at the point of use.
`ifndef MAX_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MHPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MHPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/mhpq_pkg.sv
// Shared types and constants of the max-heap priority queue core.
// No dependencies; used by the sift engine and the top level.
package mhpq_pkg;

    localparam int KEY_W  = 32;
    localparam int ST_W   = 2;
    localparam int FILL_W = 11;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [ST_W-1:0]         t_status;

    // Request commands.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Result status codes.
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    typedef struct packed {
        logic command;
        t_key key_in;
    } t_req;

    typedef struct packed {
        t_key              removed_key;
        t_status           status;
        logic [FILL_W-1:0] fill_count;
    } t_rsp;

endpackage

FILE: hw/rtl/mhpq_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/mhpq_engine.sv
// Sift engine of the max-heap priority queue: element count and the
// read-modify-write sequencer over the heap RAM. Depends on mhpq_pkg.
module mhpq_engine #(
    parameter int CAPACITY = 1024,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  mhpq_pkg::t_req  i_req,
    output logic            o_idle,
    output logic            o_done,
    input  logic            i_free,
    output mhpq_pkg::t_rsp  o_rsp,
    output logic            o_ram_we,
    output logic [AW-1:0]   o_ram_waddr,
    output mhpq_pkg::t_key  o_ram_wdata,
    output logic            o_ram_re,
    output logic [AW-1:0]   o_ram_raddr,
    input  mhpq_pkg::t_key  i_ram_rdata
);

    import mhpq_pkg::*;

    localparam int XW = AW + 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP,
        S_UP_FIN,
        S_RM_ROOT,
        S_RM_LAST,
        S_DN_L,
        S_DN_R,
        S_DN_FIN,
        S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_cidx, n_cidx;
    t_key          r_key, n_key;
    t_key          r_cval, n_cval;
    t_key          r_removed, n_removed;
    t_status       r_status, n_status;

    logic [XW-1:0] w_cnt_x;
    logic [AW-1:0] w_cnt_a;
    logic [AW-1:0] w_cnt_parent;
    logic [AW-1:0] w_last;
    logic [AW-1:0] w_parent;
    logic [AW-1:0] w_gparent;
    logic [XW-1:0] w_child_l;
    logic [XW-1:0] w_child_r;
    logic          w_sel_r;
    t_key          w_best_val;
    logic [AW-1:0] w_best_idx;
    logic [XW-1:0] w_gchild;
    logic          w_decide;

    assign w_cnt_x      = XW'(r_count);
    assign w_cnt_a      = AW'(r_count);
    assign w_cnt_parent = (w_cnt_a - AW'(1)) >> 1;
    assign w_last       = AW'(r_count - CW'(1));
    assign w_parent     = (r_pos - AW'(1)) >> 1;
    assign w_gparent    = (w_parent - AW'(1)) >> 1;
    assign w_child_l    = XW'({r_pos, 1'b1});
    assign w_child_r    = w_child_l + XW'(1);

    // The right child wins only when strictly greater than the left one.
    assign w_sel_r    = (r_state == S_DN_R) && (i_ram_rdata > r_cval);
    assign w_best_val = (r_state == S_DN_L) ? i_ram_rdata :
                        (w_sel_r ? i_ram_rdata : r_cval);
    assign w_best_idx = (r_state == S_DN_L) ? AW'(w_child_l) :
                        (w_sel_r ? AW'(w_child_r) : r_cidx);
    assign w_gchild   = XW'({w_best_idx, 1'b1});
    assign w_decide   = ((r_state == S_DN_L) && (w_child_r >= w_cnt_x)) ||
                        (r_state == S_DN_R);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_cidx      = r_cidx;
        n_key       = r_key;
        n_cval      = r_cval;
        n_removed   = r_removed;
        n_status    = r_status;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_pos;
        o_ram_wdata = r_key;
        o_ram_re    = 1'b0;
        o_ram_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_removed = '0;
                    n_status  = ST_OK;
                    if (i_req.command == CMD_INSERT) begin
                        if (r_count >= CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else if (r_count == '0) begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = '0;
                            o_ram_wdata = i_req.key_in;
                            n_count     = r_count + CW'(1);
                            n_state     = S_DONE;
                        end else begin
                            n_pos       = w_cnt_a;
                            n_key       = i_req.key_in;
                            o_ram_re    = 1'b1;
                            o_ram_raddr = w_cnt_parent;
                            n_state     = S_UP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            o_ram_re    = 1'b1;
                            o_ram_raddr = '0;
                            n_state     = S_RM_ROOT;
                        end
                    end
                end
            end
            S_UP: begin
                if (r_key > i_ram_rdata) begin
                    o_ram_we    = 1'b1;
                    o_ram_wdata = i_ram_rdata;
                    n_pos       = w_parent;
                    if (w_parent == '0) begin
                        n_state = S_UP_FIN;
                    end else begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = w_gparent;
                    end
                end else begin
                    o_ram_we = 1'b1;
                    n_count  = r_count + CW'(1);
                    n_state  = S_DONE;
                end
            end
            S_UP_FIN: begin
                o_ram_we = 1'b1;
                n_count  = r_count + CW'(1);
                n_state  = S_DONE;
            end
            S_RM_ROOT: begin
                n_removed   = i_ram_rdata;
                n_count     = r_count - CW'(1);
                o_ram_re    = 1'b1;
                o_ram_raddr = w_last;
                n_state     = S_RM_LAST;
            end
            S_RM_LAST: begin
                n_key = i_ram_rdata;
                n_pos = '0;
                if (r_count == '0) begin
                    n_state = S_DONE;
                end else if (r_count == CW'(1)) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = '0;
                    o_ram_wdata = i_ram_rdata;
                    n_state     = S_DONE;
                end else begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = AW'(1);
                    n_state     = S_DN_L;
                end
            end
            S_DN_L: begin
                n_cval = i_ram_rdata;
                n_cidx = AW'(w_child_l);
                if (w_child_r < w_cnt_x) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = AW'(w_child_r);
                    n_state     = S_DN_R;
                end
            end
            S_DN_R: begin
                n_state = r_state;
            end
            S_DN_FIN: begin
                o_ram_we = 1'b1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // One level of sift-down: the larger child either moves up into the
        // hole, or the sifted key settles in the hole.
        if (w_decide) begin
            o_ram_we = 1'b1;
            if (w_best_val > r_key) begin
                o_ram_wdata = w_best_val;
                n_pos       = w_best_idx;
                if (w_gchild < w_cnt_x) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = AW'(w_gchild);
                    n_state     = S_DN_L;
                end else begin
                    n_state = S_DN_FIN;
                end
            end else begin
                n_state = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_cidx    <= n_cidx;
        r_key     <= n_key;
        r_cval    <= n_cval;
        r_removed <= n_removed;
        r_status  <= n_status;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);

    assign o_rsp.removed_key = r_removed;
    assign o_rsp.status      = r_status;
    assign o_rsp.fill_count  = FILL_W'(r_count);

endmodule

FILE: hw/rtl/max_heap_priority_queue_core.sv
// Top level of the max-heap priority queue: sift engine, heap RAM and
// response register. Depends on mhpq_pkg, mhpq_ram, mhpq_engine and the assert header.
//
//  Channel   | Valid        | Stall        | Payload (mhpq_pkg)
//  ----------+--------------+--------------+---------------------------------
//  request   | i_req_valid  | o_req_stall  | i_req : t_req (command, key_in)
//  response  | o_rsp_valid  | i_rsp_stall  | o_rsp : t_rsp (key, status, fill)
//
// An insert sifts the new key up level by level; a remove sifts the last key down level
// by level, as the one RAM read port reads the children in turn. Rejected requests and
// an insert into an empty queue go straight to the result without a sift.
// Reset is synchronous and active low; it empties the queue but leaves the heap RAM as is.
// The next request is taken once the result has gone to the response register; a stalled response holds it off.
`include "max_heap_priority_queue_core_assert.svh"

module max_heap_priority_queue_core #(
    parameter int CAPACITY = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_stall,
    input  mhpq_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_stall,
    output mhpq_pkg::t_rsp o_rsp
);

    import mhpq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Engine status towards the response side.
    logic          w_idle;
    logic          w_done;
    logic          w_free;
    t_rsp          w_rsp;

    // Heap RAM port.
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    t_key          w_ram_wdata;
    logic          w_ram_re;
    logic [AW-1:0] w_ram_raddr;
    t_key          w_ram_rdata;

    // Response register.
    logic          r_rsp_valid;
    t_rsp          r_rsp;

    // The engine may retire its result whenever the response register is
    // empty or is being emptied in this cycle.
    assign w_free = !r_rsp_valid || !i_rsp_stall;

    mhpq_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_req_valid),
        .i_req       (i_req),
        .o_idle      (w_idle),
        .o_done      (w_done),
        .i_free      (w_free),
        .o_rsp       (w_rsp),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    mhpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (w_done && w_free) begin
            r_rsp <= w_rsp;
        end
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_free) begin
            r_rsp_valid <= w_done;
        end
    end

    // A request is only taken while the engine sits idle.
    assign o_req_stall = !w_idle;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // The sequencer never reads an entry in the cycle it rewrites it.
    `MHPQ_ASSERT_NOW(a_no_rw_overlap, w_ram_we && w_ram_re, w_ram_waddr != w_ram_raddr, "heap RAM read and write hit the same entry")
    // Once a request is taken the engine is busy in the following cycle.
    `MHPQ_ASSERT_NEXT(a_busy_after_accept, i_req_valid && !o_req_stall, o_req_stall, "engine took a request but did not go busy")
    // A full status can only be reported with the queue at capacity.
    `MHPQ_ASSERT_NOW(a_full_count, o_rsp_valid && (o_rsp.status == ST_FULL), o_rsp.fill_count == FILL_W'(CAPACITY), "full status with a count below capacity")
    // An empty status carries an empty queue and no key.
    `MHPQ_ASSERT_NOW(a_empty_rsp, o_rsp_valid && (o_rsp.status == ST_EMPTY), (o_rsp.fill_count == '0) && (o_rsp.removed_key == '0), "empty status with a non-zero count or key")

endmodule
